// File: hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// shared types, token codes and character helpers for the source token lexer
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int OFFSET_BITS   = 24;
  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 16;

  // result fields rounded up to whole bytes
  localparam int OUT_TDATA_BITS =
    ((6 + 3 + OFFSET_BITS + LENGTH_BITS + 2 * POSITION_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    M_IDLE, M_NUMBER, M_NAME, M_CHAR_BODY, M_CHAR_ESC, M_CHAR_CLOSE,
    M_STRING, M_OPERATOR, M_SLASH, M_LINE, M_BLOCK
  } mode_t;

  typedef enum logic [5:0] {
    T_INT, T_FLOAT, T_CHAR, T_STRING, T_NAME, T_IF, T_WHILE, T_BREAK,
    T_FUNC, T_RETURN, T_LET, T_FALSE, T_TRUE, T_PLUS, T_MINUS, T_ARROW,
    T_STAR, T_POW, T_SLASH, T_PERCENT, T_NOT, T_NE, T_BAND, T_LAND, T_BOR,
    T_LOR, T_BNOT, T_XOR, T_LT, T_LE, T_SHL, T_GT, T_GE, T_SHR, T_ASSIGN,
    T_EQ, T_LPAREN, T_RPAREN, T_LBRACE, T_RBRACE, T_LBRACKET, T_RBRACKET,
    T_COMMA, T_COLON, T_SEMI, T_EOF
  } tok_t;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_BAD_LIT   = 3'd2;
  localparam logic [2:0] E_OPEN_STR  = 3'd3;
  localparam logic [2:0] E_OPEN_CMT  = 3'd4;

  typedef struct packed {
    logic [5:0]               token_kind;
    logic [2:0]               error_code;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [LENGTH_BITS-1:0]   token_length;
    logic [POSITION_BITS-1:0] start_row;
    logic [POSITION_BITS-1:0] start_column;
  } tok_res_t;

  typedef struct packed {
    logic     valid;
    tok_res_t res;
  } tok_slot_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_name(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] r;
    r = 7'h40;
    unique case (b)
      8'h2b: r = {1'b0, T_PLUS};
      8'h25: r = {1'b0, T_PERCENT};
      8'h7e: r = {1'b0, T_BNOT};
      8'h5e: r = {1'b0, T_XOR};
      8'h28: r = {1'b0, T_LPAREN};
      8'h29: r = {1'b0, T_RPAREN};
      8'h7b: r = {1'b0, T_LBRACE};
      8'h7d: r = {1'b0, T_RBRACE};
      8'h5b: r = {1'b0, T_LBRACKET};
      8'h5d: r = {1'b0, T_RBRACKET};
      8'h2c: r = {1'b0, T_COMMA};
      8'h3a: r = {1'b0, T_COLON};
      8'h3b: r = {1'b0, T_SEMI};
      default: r = 7'h40;
    endcase
    return r;
  endfunction

  function automatic logic is_op_start(input logic [7:0] b);
    return b == 8'h2d || b == 8'h2a || b == 8'h21 || b == 8'h26 ||
           b == 8'h7c || b == 8'h3c || b == 8'h3e || b == 8'h3d;
  endfunction

  function automatic tok_t op_single(input logic [7:0] p);
    tok_t r;
    unique case (p)
      8'h2d: r = T_MINUS;
      8'h2a: r = T_STAR;
      8'h21: r = T_NOT;
      8'h26: r = T_BAND;
      8'h7c: r = T_BOR;
      8'h3c: r = T_LT;
      8'h3e: r = T_GT;
      default: r = T_ASSIGN;
    endcase
    return r;
  endfunction

  // bit 6 set means no two-character operator
  function automatic logic [6:0] op_double(input logic [7:0] p, input logic [7:0] b);
    logic [6:0] r;
    r = 7'h40;
    unique case (p)
      8'h2d: if (b == 8'h3e) r = {1'b0, T_ARROW};
      8'h2a: if (b == 8'h2a) r = {1'b0, T_POW};
      8'h21: if (b == 8'h3d) r = {1'b0, T_NE};
      8'h26: if (b == 8'h26) r = {1'b0, T_LAND};
      8'h7c: if (b == 8'h7c) r = {1'b0, T_LOR};
      8'h3d: if (b == 8'h3d) r = {1'b0, T_EQ};
      8'h3c: begin
        if (b == 8'h3d) r = {1'b0, T_LE};
        else if (b == 8'h3c) r = {1'b0, T_SHL};
      end
      8'h3e: begin
        if (b == 8'h3d) r = {1'b0, T_GE};
        else if (b == 8'h3e) r = {1'b0, T_SHR};
      end
      default: r = 7'h40;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/stl_keyword.sv
// ----------------------------------------------------------------------------
// stl_keyword
// classifies a finished name as one of the eight keywords or a plain name
// ----------------------------------------------------------------------------
module stl_keyword
  import stl_pkg::*;
(
  input  logic [47:0]            kw_buf,
  input  logic [LENGTH_BITS-1:0] len,
  output tok_t                   kind
);

  always_comb begin
    kind = T_NAME;
    if (len == LENGTH_BITS'(2) && kw_buf == 48'h6966) kind = T_IF;
    else if (len == LENGTH_BITS'(5) && kw_buf == 48'h7768696c65) kind = T_WHILE;
    else if (len == LENGTH_BITS'(5) && kw_buf == 48'h627265616b) kind = T_BREAK;
    else if (len == LENGTH_BITS'(4) && kw_buf == 48'h66756e63) kind = T_FUNC;
    else if (len == LENGTH_BITS'(6) && kw_buf == 48'h72657475726e) kind = T_RETURN;
    else if (len == LENGTH_BITS'(3) && kw_buf == 48'h6c6574) kind = T_LET;
    else if (len == LENGTH_BITS'(5) && kw_buf == 48'h66616c7365) kind = T_FALSE;
    else if (len == LENGTH_BITS'(4) && kw_buf == 48'h74727565) kind = T_TRUE;
  end

endmodule

// File: hdl/stl_scan.sv
// ----------------------------------------------------------------------------
// stl_scan
// lexer state machine: one request per cycle, up to two result slots
// ----------------------------------------------------------------------------
module stl_scan
  import stl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] char_byte,
  output tok_slot_t  slot0,
  output tok_slot_t  slot1
);

  localparam logic [OFFSET_BITS-1:0]   OMAX = '1;
  localparam logic [POSITION_BITS-1:0] PMAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LMAX = '1;

  mode_t                    mode_r, mode_nxt;
  logic [7:0]               pend_op_r, pend_op_nxt;
  logic                     dot_r, dot_nxt, esc_r, esc_nxt, star_r, star_nxt;
  logic                     halt_r, halt_nxt;
  logic [47:0]              kw_r, kw_nxt;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt, tstart_r, tstart_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt, len_grow;
  logic [POSITION_BITS-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [POSITION_BITS-1:0] frow_r, frow_nxt, fcol_r, fcol_nxt;
  tok_t                     name_kind;
  logic [6:0]               dbl, sgl;
  logic                     ws, to_idle;
  tok_slot_t                s0, s1;

  stl_keyword u_kw (.kw_buf(kw_r), .len(len_r), .kind(name_kind));

  assign len_grow = (len_r != LMAX) ? len_r + LENGTH_BITS'(1) : len_r;
  assign dbl      = op_double(pend_op_r, char_byte);
  assign sgl      = single_kind(char_byte);
  assign ws       = char_byte == 8'h20 || (char_byte >= 8'd9 && char_byte <= 8'd13);

  function automatic tok_res_t mk(input tok_t k, input logic [2:0] e,
                                  input logic [OFFSET_BITS-1:0] o,
                                  input logic [LENGTH_BITS-1:0] l,
                                  input logic [POSITION_BITS-1:0] r,
                                  input logic [POSITION_BITS-1:0] c);
    tok_res_t t;
    t.token_kind   = k;
    t.error_code   = e;
    t.start_offset = o;
    t.token_length = l;
    t.start_row    = r;
    t.start_column = c;
    return t;
  endfunction

  always_comb begin
    mode_nxt    = mode_r;
    pend_op_nxt = pend_op_r;
    dot_nxt     = dot_r;
    esc_nxt     = esc_r;
    star_nxt    = star_r;
    halt_nxt    = halt_r;
    kw_nxt      = kw_r;
    off_nxt     = off_r;
    tstart_nxt  = tstart_r;
    len_nxt     = len_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    frow_nxt    = frow_r;
    fcol_nxt    = fcol_r;
    s0          = '0;
    s1          = '0;
    to_idle     = 1'b0;
    if (step) begin
      if (kind) begin
        // end of text: flush, then end of file
        if (!halt_r) begin
          unique case (mode_r)
            M_NUMBER: s0 = {1'b1, mk(dot_r ? T_FLOAT : T_INT, E_NONE, tstart_r, len_r,
                                     frow_r, fcol_r)};
            M_NAME: s0 = {1'b1, mk(name_kind, E_NONE, tstart_r, len_r, frow_r, fcol_r)};
            M_OPERATOR: s0 = {1'b1, mk(op_single(pend_op_r), E_NONE, tstart_r,
                                       LENGTH_BITS'(1), frow_r, fcol_r)};
            M_SLASH: s0 = {1'b1, mk(T_SLASH, E_NONE, tstart_r, LENGTH_BITS'(1),
                                    frow_r, fcol_r)};
            M_CHAR_BODY, M_CHAR_ESC, M_CHAR_CLOSE:
              s0 = {1'b1, mk(T_INT, E_BAD_LIT, tstart_r, '0, frow_r, fcol_r)};
            M_STRING: s0 = {1'b1, mk(T_INT, E_OPEN_STR, tstart_r, '0, frow_r, fcol_r)};
            M_BLOCK: s0 = {1'b1, mk(T_INT, E_OPEN_CMT, tstart_r, '0, frow_r, fcol_r)};
            default: ;
          endcase
        end
        s1 = {1'b1, mk(T_EOF, E_NONE, off_r, '0, row_r, col_r)};
        mode_nxt    = M_IDLE;
        pend_op_nxt = '0;
        dot_nxt     = 1'b0;
        esc_nxt     = 1'b0;
        star_nxt    = 1'b0;
        halt_nxt    = 1'b0;
        kw_nxt      = '0;
        off_nxt     = '0;
        tstart_nxt  = '0;
        len_nxt     = '0;
        row_nxt     = POSITION_BITS'(1);
        col_nxt     = POSITION_BITS'(1);
        frow_nxt    = POSITION_BITS'(1);
        fcol_nxt    = POSITION_BITS'(1);
      end else begin
        if (!halt_r) begin
          unique case (mode_r)
            M_NUMBER: begin
              if (is_digit(char_byte)) len_nxt = len_grow;
              else if (char_byte == 8'h2e && !dot_r) begin
                dot_nxt = 1'b1;
                len_nxt = len_grow;
              end else begin
                s0 = {1'b1, mk(dot_r ? T_FLOAT : T_INT, E_NONE, tstart_r, len_r,
                               frow_r, fcol_r)};
                to_idle = 1'b1;
              end
            end
            M_NAME: begin
              if (is_name(char_byte)) begin
                if (len_r < LENGTH_BITS'(6)) kw_nxt = {kw_r[39:0], char_byte};
                len_nxt = len_grow;
              end else begin
                s0 = {1'b1, mk(name_kind, E_NONE, tstart_r, len_r, frow_r, fcol_r)};
                to_idle = 1'b1;
              end
            end
            M_CHAR_BODY: begin
              len_nxt  = len_grow;
              mode_nxt = (char_byte == 8'h5c) ? M_CHAR_ESC : M_CHAR_CLOSE;
            end
            M_CHAR_ESC: begin
              len_nxt  = len_grow;
              mode_nxt = M_CHAR_CLOSE;
            end
            M_CHAR_CLOSE: begin
              mode_nxt = M_IDLE;
              if (char_byte == 8'h27) begin
                len_nxt = len_grow;
                s0 = {1'b1, mk(T_CHAR, E_NONE, tstart_r, len_grow, frow_r, fcol_r)};
              end else begin
                s0 = {1'b1, mk(T_INT, E_BAD_LIT, tstart_r, '0, frow_r, fcol_r)};
                halt_nxt = 1'b1;
              end
            end
            M_STRING: begin
              len_nxt = len_grow;
              if (esc_r) esc_nxt = 1'b0;
              else if (char_byte == 8'h5c) esc_nxt = 1'b1;
              else if (char_byte == 8'h22) begin
                s0 = {1'b1, mk(T_STRING, E_NONE, tstart_r, len_grow, frow_r, fcol_r)};
                mode_nxt = M_IDLE;
              end
            end
            M_OPERATOR: begin
              if (!dbl[6]) begin
                s0 = {1'b1, mk(tok_t'(dbl[5:0]), E_NONE, tstart_r, LENGTH_BITS'(2),
                               frow_r, fcol_r)};
                mode_nxt = M_IDLE;
              end else begin
                s0 = {1'b1, mk(op_single(pend_op_r), E_NONE, tstart_r,
                               LENGTH_BITS'(1), frow_r, fcol_r)};
                to_idle = 1'b1;
              end
            end
            M_SLASH: begin
              if (char_byte == 8'h2f) mode_nxt = M_LINE;
              else if (char_byte == 8'h2a) begin
                mode_nxt = M_BLOCK;
                star_nxt = 1'b0;
              end else begin
                s0 = {1'b1, mk(T_SLASH, E_NONE, tstart_r, LENGTH_BITS'(1),
                               frow_r, fcol_r)};
                to_idle = 1'b1;
              end
            end
            M_LINE: if (char_byte == 8'h0a) mode_nxt = M_IDLE;
            M_BLOCK: begin
              if (star_r && char_byte == 8'h2f) mode_nxt = M_IDLE;
              else star_nxt = (char_byte == 8'h2a);
            end
            default: to_idle = 1'b1;
          endcase
          if (to_idle) begin
            // byte starts a new construct from idle
            mode_nxt = M_IDLE;
            if (!ws) begin
              tstart_nxt = off_r;
              frow_nxt   = row_r;
              fcol_nxt   = col_r;
              len_nxt    = LENGTH_BITS'(1);
              if (is_digit(char_byte)) begin
                mode_nxt = M_NUMBER;
                dot_nxt  = 1'b0;
              end else if (is_name(char_byte)) begin
                mode_nxt = M_NAME;
                kw_nxt   = {40'd0, char_byte};
              end else if (char_byte == 8'h27) mode_nxt = M_CHAR_BODY;
              else if (char_byte == 8'h22) begin
                mode_nxt = M_STRING;
                esc_nxt  = 1'b0;
              end else if (char_byte == 8'h2f) mode_nxt = M_SLASH;
              else if (!sgl[6]) begin
                s1 = {1'b1, mk(tok_t'(sgl[5:0]), E_NONE, off_r, LENGTH_BITS'(1),
                               row_r, col_r)};
              end else if (is_op_start(char_byte)) begin
                mode_nxt    = M_OPERATOR;
                pend_op_nxt = char_byte;
              end else begin
                s1 = {1'b1, mk(T_INT, E_BAD_CHAR, off_r, '0, row_r, col_r)};
                halt_nxt = 1'b1;
              end
            end
          end
        end
        if (off_r != OMAX) off_nxt = off_r + OFFSET_BITS'(1);
        if (char_byte == 8'h0a) begin
          if (row_r != PMAX) row_nxt = row_r + POSITION_BITS'(1);
          col_nxt = POSITION_BITS'(1);
        end else if (col_r != PMAX) begin
          col_nxt = col_r + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      pend_op_r <= '0;
      dot_r     <= 1'b0;
      esc_r     <= 1'b0;
      star_r    <= 1'b0;
      halt_r    <= 1'b0;
      kw_r      <= '0;
      off_r     <= '0;
      tstart_r  <= '0;
      len_r     <= '0;
      row_r     <= POSITION_BITS'(1);
      col_r     <= POSITION_BITS'(1);
      frow_r    <= POSITION_BITS'(1);
      fcol_r    <= POSITION_BITS'(1);
    end else begin
      mode_r    <= mode_nxt;
      pend_op_r <= pend_op_nxt;
      dot_r     <= dot_nxt;
      esc_r     <= esc_nxt;
      star_r    <= star_nxt;
      halt_r    <= halt_nxt;
      kw_r      <= kw_nxt;
      off_r     <= off_nxt;
      tstart_r  <= tstart_nxt;
      len_r     <= len_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      frow_r    <= frow_nxt;
      fcol_r    <= fcol_nxt;
    end
  end

  assign slot0 = s0;
  assign slot1 = s1;

endmodule

// File: hdl/stl_out_queue.sv
// ----------------------------------------------------------------------------
// stl_out_queue
// four-entry result queue; accepts up to two results per cycle
// ----------------------------------------------------------------------------
module stl_out_queue
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_slot_t slot0,
  input  tok_slot_t slot1,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_res_t  out_res,
  output logic      out_last
);

  typedef struct packed {
    tok_res_t res;
    logic     last;
  } q_ent_t;

  q_ent_t     q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] n_push;
  q_ent_t     e0, e1;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_res   = q_r[rp_r].res;
  assign out_last  = q_r[rp_r].last;
  assign room      = cnt_r <= 3'd2;

  always_comb begin
    n_push = '0;
    e0 = '0;
    e1 = '0;
    if (push) begin
      if (slot0.valid && slot1.valid) begin
        n_push = 2'd2;
        e0 = '{res: slot0.res, last: 1'b0};
        e1 = '{res: slot1.res, last: 1'b1};
      end else if (slot0.valid) begin
        n_push = 2'd1;
        e0 = '{res: slot0.res, last: 1'b1};
      end else if (slot1.valid) begin
        n_push = 2'd1;
        e0 = '{res: slot1.res, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[wp_r] <= e0;
    if (n_push == 2'd2) q_r[wp_r + 2'd1] <= e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

// File: hdl/source_token_lexer.sv
// ----------------------------------------------------------------------------
// source_token_lexer
// streaming lexer for a small c-like language
// ----------------------------------------------------------------------------
// One request (a text byte or an end-of-text marker) is taken per cycle while
// the queue has room; the state machine updates in the same cycle and its zero
// to two tokens go into a four-entry result queue, so input keeps flowing while
// results wait. A request's tokens are registered in the queue before they reach
// the output; input stalls only when the queue has fewer than two free entries.
module source_token_lexer
  import stl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // char_byte
  input  logic                      in_tuser,   // kind
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // token_kind, error_code,
                                                // start_offset, token_length,
                                                // start_row, start_column, pad
  output logic                      out_tlast   // last_of_run
);

  localparam int PAD_BITS = OUT_TDATA_BITS - $bits(tok_res_t);

  tok_slot_t slot0, slot1;
  tok_res_t  res;
  logic      room, step;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  stl_scan u_scan (
    .clk(clk), .rst_n(rst_n), .step(step), .kind(in_tuser), .char_byte(in_tdata),
    .slot0(slot0), .slot1(slot1)
  );

  stl_out_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(step), .slot0(slot0), .slot1(slot1),
    .room(room), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_res(res), .out_last(out_tlast)
  );

  assign out_tdata = {{PAD_BITS{1'b0}}, res.start_column, res.start_row,
                      res.token_length, res.start_offset, res.error_code,
                      res.token_kind};

endmodule

// File: hdl/stl_checker.sv
// ----------------------------------------------------------------------------
// stl_checker
// port-level checks for the source token lexer
// ----------------------------------------------------------------------------
module stl_checker
  import stl_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic                      out_tlast
);

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == T_EOF |-> out_tlast)
    else $error("eof not last");

  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:6] != E_NONE |-> out_tdata[48:33] == '0)
    else $error("error with length");

  a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tvalid)
    else $error("no result after end marker");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule

bind source_token_lexer stl_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);

// File: tb/source_token_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer_tb
// self-checking bench for the streaming lexer: a table of directed requests
// and then random well-formed source text with noise and broken constructs,
// every token compared field by field with a table entry or an in-bench lexer model
// ----------------------------------------------------------------------------
module source_token_lexer_tb;
  import stl_pkg::*;

  localparam int LIMIT = 1500000;

  typedef struct {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [23:0] off;
    logic [15:0] len;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } token_t;

  typedef struct {
    bit          eot;
    logic [7:0]  b;
    bit          typed;
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [23:0] off;
    logic [15:0] row;
    logic [15:0] col;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = '0;
  logic                      in_tuser = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      out_tlast;

  source_token_lexer u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  always #5 clk = ~clk;

  // lexer model state
  mode_t       mode;
  logic [7:0]  pend_op;
  bit          dot_seen, esc_pend, was_star, halted;
  logic [47:0] kw_buf;
  logic [23:0] cur_off, tok_off;
  logic [15:0] run_len, cur_row, cur_col, tok_row, tok_col;

  token_t      tokens_due[$];
  token_t      step_tokens[$];
  int          errors = 0;
  int          tokens_seen = 0;
  int          requests = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  function automatic void lex_clear();
    mode = M_IDLE; pend_op = '0; dot_seen = 0; esc_pend = 0; was_star = 0;
    halted = 0; kw_buf = '0; cur_off = '0; tok_off = '0; run_len = '0;
    cur_row = 16'd1; cur_col = 16'd1; tok_row = 16'd1; tok_col = 16'd1;
  endfunction

  function automatic void put(logic [5:0] k, logic [2:0] e, logic [23:0] o,
                              logic [15:0] l, logic [15:0] r, logic [15:0] c);
    token_t t;
    t.kind = k; t.err = e; t.off = o; t.len = l; t.row = r; t.col = c; t.last = 0;
    if (step_tokens.size() < 2) step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void put_tok(logic [5:0] k, logic [15:0] l);
    put(k, E_NONE, tok_off, l, tok_row, tok_col);
  endfunction

  function automatic void fail_lex(logic [2:0] e);
    put(T_INT, e, tok_off, 16'd0, tok_row, tok_col);
    halted = 1;
    mode = M_IDLE;
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic void lengthen();
    if (run_len != 16'hffff) run_len++;
  endfunction

  function automatic logic [5:0] word_kind();
    if (run_len == 2 && kw_buf == "if") return T_IF;
    if (run_len == 5 && kw_buf == "while") return T_WHILE;
    if (run_len == 5 && kw_buf == "break") return T_BREAK;
    if (run_len == 4 && kw_buf == "func") return T_FUNC;
    if (run_len == 6 && kw_buf == "return") return T_RETURN;
    if (run_len == 3 && kw_buf == "let") return T_LET;
    if (run_len == 5 && kw_buf == "false") return T_FALSE;
    if (run_len == 4 && kw_buf == "true") return T_TRUE;
    return T_NAME;
  endfunction

  function automatic logic [5:0] lone_op(logic [7:0] p);
    case (p)
      "-": return T_MINUS;
      "*": return T_STAR;
      "!": return T_NOT;
      "&": return T_BAND;
      "|": return T_BOR;
      "<": return T_LT;
      ">": return T_GT;
      default: return T_ASSIGN;
    endcase
  endfunction

  // returns 1 and the kind when p,b form a two-character operator
  function automatic bit pair_op(logic [7:0] p, logic [7:0] b, output logic [5:0] k);
    k = T_INT;
    case (p)
      "-": if (b == ">") k = T_ARROW;
      "*": if (b == "*") k = T_POW;
      "!": if (b == "=") k = T_NE;
      "&": if (b == "&") k = T_LAND;
      "|": if (b == "|") k = T_LOR;
      "=": if (b == "=") k = T_EQ;
      "<": if (b == "=") k = T_LE; else if (b == "<") k = T_SHL;
      ">": if (b == "=") k = T_GE; else if (b == ">") k = T_SHR;
      default: ;
    endcase
    return k != T_INT;
  endfunction

  function automatic void start_byte(logic [7:0] b);
    logic [5:0] k;
    bit         one;
    mode = M_IDLE;
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
    tok_off = cur_off; tok_row = cur_row; tok_col = cur_col; run_len = 16'd1;
    if (digit(b)) begin mode = M_NUMBER; dot_seen = 0; return; end
    if (letter(b)) begin mode = M_NAME; kw_buf = {40'd0, b}; return; end
    if (b == "'") begin mode = M_CHAR_BODY; return; end
    if (b == "\"") begin mode = M_STRING; esc_pend = 0; return; end
    if (b == "/") begin mode = M_SLASH; return; end
    one = 1;
    case (b)
      "+": k = T_PLUS;     "%": k = T_PERCENT;  "~": k = T_BNOT;
      "^": k = T_XOR;      "(": k = T_LPAREN;   ")": k = T_RPAREN;
      "{": k = T_LBRACE;   "}": k = T_RBRACE;   "[": k = T_LBRACKET;
      "]": k = T_RBRACKET; ",": k = T_COMMA;    ":": k = T_COLON;
      ";": k = T_SEMI;
      default: one = 0;
    endcase
    if (one) begin put_tok(k, 16'd1); return; end
    if (b == "-" || b == "*" || b == "!" || b == "&" || b == "|" ||
        b == "<" || b == ">" || b == "=") begin
      mode = M_OPERATOR; pend_op = b; return;
    end
    fail_lex(E_BAD_CHAR);
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic [5:0] k;
    case (mode)
      M_NUMBER: begin
        if (digit(b)) lengthen();
        else if (b == "." && !dot_seen) begin dot_seen = 1; lengthen(); end
        else begin
          put_tok(dot_seen ? T_FLOAT : T_INT, run_len);
          start_byte(b);
        end
      end
      M_NAME: begin
        if (letter(b)) begin
          if (run_len < 6) kw_buf = {kw_buf[39:0], b};
          lengthen();
        end else begin
          put_tok(word_kind(), run_len);
          start_byte(b);
        end
      end
      M_CHAR_BODY: begin lengthen(); mode = (b == "\\") ? M_CHAR_ESC : M_CHAR_CLOSE; end
      M_CHAR_ESC: begin lengthen(); mode = M_CHAR_CLOSE; end
      M_CHAR_CLOSE: begin
        if (b == "'") begin lengthen(); put_tok(T_CHAR, run_len); mode = M_IDLE; end
        else fail_lex(E_BAD_LIT);
      end
      M_STRING: begin
        lengthen();
        if (esc_pend) esc_pend = 0;
        else if (b == "\\") esc_pend = 1;
        else if (b == "\"") begin put_tok(T_STRING, run_len); mode = M_IDLE; end
      end
      M_OPERATOR: begin
        if (pair_op(pend_op, b, k)) begin put_tok(k, 16'd2); mode = M_IDLE; end
        else begin put_tok(lone_op(pend_op), 16'd1); start_byte(b); end
      end
      M_SLASH: begin
        if (b == "/") mode = M_LINE;
        else if (b == "*") begin mode = M_BLOCK; was_star = 0; end
        else begin put_tok(T_SLASH, 16'd1); start_byte(b); end
      end
      M_LINE: if (b == "\n") mode = M_IDLE;
      M_BLOCK: begin
        if (was_star && b == "/") mode = M_IDLE;
        else was_star = (b == "*");
      end
      default: start_byte(b);
    endcase
  endfunction

  // model one request; its tokens land in step_tokens
  function automatic void lex_request(bit eot, logic [7:0] b);
    step_tokens.delete();
    if (eot) begin
      if (!halted) begin
        case (mode)
          M_NUMBER: put_tok(dot_seen ? T_FLOAT : T_INT, run_len);
          M_NAME: put_tok(word_kind(), run_len);
          M_OPERATOR: put_tok(lone_op(pend_op), 16'd1);
          M_SLASH: put_tok(T_SLASH, 16'd1);
          M_CHAR_BODY, M_CHAR_ESC, M_CHAR_CLOSE: fail_lex(E_BAD_LIT);
          M_STRING: fail_lex(E_OPEN_STR);
          M_BLOCK: fail_lex(E_OPEN_CMT);
          default: ;
        endcase
      end
      put(T_EOF, E_NONE, cur_off, 16'd0, cur_row, cur_col);
      lex_clear();
    end else begin
      if (!halted) scan_byte(b);
      if (cur_off != 24'hffffff) cur_off++;
      if (b == "\n") begin
        if (cur_row != 16'hffff) cur_row++;
        cur_col = 16'd1;
      end else if (cur_col != 16'hffff) cur_col++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1;
  endfunction

  task automatic send(bit eot, logic [7:0] b, bit typed = 0, token_t typed_tok = '{default: 0});
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= eot;
    in_tdata  <= eot ? 8'($urandom) : b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests++;
    lex_request(eot, b);
    if (typed) tokens_due.insert(tokens_due.size(), typed_tok);
    else foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send(0, s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic string rand_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 1) ?
        $urandom_range("a", "z") : $urandom_range("A", "Z")))};
    return s;
  endfunction

  task automatic random_text(int n_tok);
    string kw[8] = '{"if", "while", "break", "func", "return", "let", "false", "true"};
    string ops = "+-*/%!&|~^<>=(){}[],:;";
    string s;
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 13))
        0: s = kw[$urandom_range(0, 7)];
        1: s = {rand_word($urandom_range(1, 8)), "_"};
        2: s = $sformatf("%0d", $urandom_range(0, 99999));
        3: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
        4: s = {string'(ops[$urandom_range(0, ops.len()-1)]),
                string'(ops[$urandom_range(0, ops.len()-1)])};
        5: s = string'(ops[$urandom_range(0, ops.len()-1)]);
        6: s = {"\"", rand_word($urandom_range(0, 4)), "\\\"", "\\\\", "\""};
        7: s = $urandom_range(0, 1) ? {"'", rand_word(1), "'"} : "'\\n'";
        8: s = {"// ", rand_word(3), "\n"};
        9: s = {"/* *", rand_word(2), " **/"};
        10: s = $urandom_range(0, 1) ? "\n" : "\t ";
        11: s = "1..";
        default: s = " ";
      endcase
      send_text(s);
      if ($urandom_range(0, 60) == 0) send(0, 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) send_text(string'(8'($urandom_range(0, 1) ? "'" : "\"")));
    send(1, 8'd0);
  endtask

  // results: compare with the oldest expectation, then pick next ready
  always @(posedge clk) begin
    token_t e;
    token_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.kind = out_tdata[5:0];   a.err = out_tdata[8:6];   a.off = out_tdata[32:9];
      a.len  = out_tdata[48:33]; a.row = out_tdata[64:49];
      a.col  = out_tdata[80:65];
      a.last = out_tlast;
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t unexpected token kind %0d err %0d off %0d", $time,
                 a.kind, a.err, a.off);
      end else begin
        e = tokens_due.pop_front();
        if (e != a) begin
          errors++;
          $display("%0t mismatch exp kind %0d err %0d off %0d len %0d row %0d col %0d last %0d",
                   $time, e.kind, e.err, e.off, e.len, e.row, e.col, e.last);
          $display("%0t          act kind %0d err %0d off %0d len %0d row %0d col %0d last %0d",
                   $time, a.kind, a.err, a.off, a.len, a.row, a.col, a.last);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t dir[$] = '{
      '{0, 8'h80, 1, T_INT, E_BAD_CHAR, 24'd0, 16'd1, 16'd1},
      '{1, 8'h00, 1, T_EOF, E_NONE, 24'd1, 16'd1, 16'd2},
      '{0, "1", 0, 0, 0, 0, 0, 0}, '{0, ".", 0, 0, 0, 0, 0, 0},
      '{0, ".", 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0, 0},
      '{0, "'", 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0, 0},
      '{0, "/", 0, 0, 0, 0, 0, 0}, '{0, "*", 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{0, "\"", 0, 0, 0, 0, 0, 0}, '{0, "\\", 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0},
      '{0, "a", 0, 0, 0, 0, 0, 0}, '{0, "1", 0, 0, 0, 0, 0, 0},
      '{0, "<", 0, 0, 0, 0, 0, 0}, '{0, "\n", 0, 0, 0, 0, 0, 0},
      '{0, "'", 0, 0, 0, 0, 0, 0}, '{0, "x", 0, 0, 0, 0, 0, 0},
      '{0, "y", 0, 0, 0, 0, 0, 0}, '{0, 8'hff, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 0, 0, 0}
    };
    token_t tt;
    lex_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 30; recv_idle = 49;
    foreach (dir[i]) begin
      tt = '{dir[i].kind, dir[i].err, dir[i].off, 16'd0, dir[i].row, dir[i].col, 1'b1};
      send(dir[i].eot, dir[i].b, dir[i].typed, tt);
    end
    drain();

    while (requests < 450) random_text($urandom_range(2, 25));
    drain();
    send_idle = 49; recv_idle = 30;
    while (requests < 850) random_text($urandom_range(2, 25));
    drain();
    send_idle = 0; recv_idle = 0;
    while (requests < 1100) random_text($urandom_range(2, 25));
    drain();

    $display("%0d requests sent, %0d tokens checked: all token kinds, lexing errors,",
             requests, tokens_seen);
    $display("comments, literals, end-of-text flushes, three stall mixes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
